FILE: hdl/wcsm_pkg.sv
// ----------------------------------------------------------------------------
// wcsm_pkg - shared types and constants for the wheel speed meter
// Field widths, register indexes and the divider status bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package wcsm_pkg;

    // payload field widths
    localparam int CHAN_W     = 2;
    localparam int COUNT_W    = 32;
    localparam int SPEED_W    = 16;
    localparam int PERIOD_W   = 32;

    // register widths
    localparam int DIST_W     = 20;
    localparam int PPT_W      = 16;
    localparam int TICK_W     = 28;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 28;

    // arithmetic widths
    localparam int MUL_W      = 32;                 // shared multiplier operand width
    localparam int NUM_W      = DIST_W + TICK_W;    // distance * tick rate
    localparam int K_W        = 26;                 // 1000 * pulses_per_turn fits here
    localparam int UM_PER_MM  = 1000;

    localparam int CAPTURE_BITS_DEF = 32;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_WHEEL_CHANNEL = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DISTANCE      = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_PULSES        = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_TICK_HZ       = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_SPEED     = 3'd4;

    // register reset values
    localparam logic [CHAN_W-1:0]  RST_WHEEL_CHANNEL = 2'd0;
    localparam logic [DIST_W-1:0]  RST_DISTANCE      = 20'd100000;
    localparam logic [PPT_W-1:0]   RST_PULSES        = 16'd1;
    localparam logic [TICK_W-1:0]  RST_TICK_HZ       = 28'd1000000;
    localparam logic [SPEED_W-1:0] RST_MAX_SPEED     = 16'd10000;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

`default_nettype wire

FILE: hdl/wcsm_mul.sv
// ----------------------------------------------------------------------------
// wcsm_mul - shared registered multiplier
// One unsigned multiply per cycle, product registered.
// ----------------------------------------------------------------------------
`default_nettype none

module wcsm_mul (
    input  wire logic                            aclk,
    input  wire logic [wcsm_pkg::MUL_W-1:0]      op_a,
    input  wire logic [wcsm_pkg::MUL_W-1:0]      op_b,
    output logic      [2*wcsm_pkg::MUL_W-1:0]    prod_reg
);
    import wcsm_pkg::*;

    logic [2*MUL_W-1:0] prod_next;

    assign prod_next = op_a * op_b;

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

endmodule

`default_nettype wire

FILE: hdl/wcsm_div.sv
// ----------------------------------------------------------------------------
// wcsm_div - iterative restoring divider
// One quotient bit per cycle until all NUM_W dividend bits are shifted through.
// ----------------------------------------------------------------------------
`default_nettype none

module wcsm_div #(
    parameter int NUM_W = wcsm_pkg::NUM_W,
    parameter int DEN_W = wcsm_pkg::K_W + wcsm_pkg::CAPTURE_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [NUM_W-1:0]             dividend,
    input  wire logic [DEN_W-1:0]             divisor,
    output wcsm_pkg::div_status_t             status,
    output logic      [NUM_W-1:0]             quotient
);
    import wcsm_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    // shift in the next dividend bit and try one subtraction
    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb begin
        quo_next = {quo_reg[NUM_W-2:0], fits};
        rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule

`default_nettype wire

FILE: hdl/wheel_capture_speed_meter_core.sv
// ----------------------------------------------------------------------------
// wheel_capture_speed_meter_core - wheel speed from timer capture events
// A wheel capture runs through S_NUM, S_K, S_DEN, S_LOAD, the 48-step divider
// in S_DIV and S_OUT; a new capture is taken only back in S_IDLE.
// Captures on other channels, the seeding capture and zero periods start no calculation.
// s_tready is low while a speed calculation runs, and while a finished result
// waits for the previous result transfer.
// Reset (aresetn low, synchronous) restores register defaults and forgets the
// stored capture count.
// ----------------------------------------------------------------------------
`default_nettype none

module wheel_capture_speed_meter_core #(
    parameter int CAPTURE_BITS = wcsm_pkg::CAPTURE_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // input capture events
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [wcsm_pkg::COUNT_W-1:0]        s_tdata,  // capture_count
    input  wire logic [wcsm_pkg::CHAN_W-1:0]         s_tuser,  // capture_channel
    // speed results
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [wcsm_pkg::SPEED_W+wcsm_pkg::PERIOD_W-1:0] m_tdata, // speed_mm_s, period_ticks
    output logic                                     m_tuser,  // speed_saturated
    // configuration writes
    input  wire logic                                cfg_wr_en,
    input  wire logic [wcsm_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [wcsm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import wcsm_pkg::*;

    localparam int DEN_W = K_W + CAPTURE_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_NUM,
        S_K,
        S_DEN,
        S_LOAD,
        S_DIV,
        S_OUT
    } state_t;

    state_t state_reg;

    // configuration
    logic [CHAN_W-1:0]  chan_cfg_reg;
    logic [DIST_W-1:0]  dist_cfg_reg;
    logic [PPT_W-1:0]   ppt_cfg_reg;
    logic [TICK_W-1:0]  tick_cfg_reg;
    logic [SPEED_W-1:0] max_cfg_reg;

    // capture state
    logic [CAPTURE_BITS-1:0] prev_count_reg;
    logic                    have_prev_reg;
    logic [CAPTURE_BITS-1:0] now_count;
    logic [CAPTURE_BITS-1:0] period_next;
    logic [CAPTURE_BITS-1:0] period_reg;

    // arithmetic
    logic [MUL_W-1:0]   mul_a;
    logic [MUL_W-1:0]   mul_b;
    logic [2*MUL_W-1:0] prod;
    logic [NUM_W-1:0]   num_reg;
    logic               den_zero_reg;
    logic               div_start;
    div_status_t        div_st;
    logic [NUM_W-1:0]   quotient;
    logic               sat;
    logic [SPEED_W-1:0] speed;

    logic in_xfer;
    logic out_free;

    assign s_tready  = (state_reg == S_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign out_free  = !m_tvalid || m_tready;
    assign now_count = s_tdata[CAPTURE_BITS-1:0];
    assign period_next = now_count - prev_count_reg;
    assign div_start = (state_reg == S_LOAD);

    // operand select for the shared multiplier
    always_comb begin
        unique case (state_reg)
            S_NUM: begin
                mul_a = MUL_W'(dist_cfg_reg);
                mul_b = MUL_W'(tick_cfg_reg);
            end
            S_K: begin
                mul_a = MUL_W'(UM_PER_MM);
                mul_b = MUL_W'(ppt_cfg_reg);
            end
            default: begin
                // 1000 * pulses_per_turn times the period
                mul_a = MUL_W'(prod[K_W-1:0]);
                mul_b = MUL_W'(period_reg);
            end
        endcase
    end

    wcsm_mul u_mul (
        .aclk     (aclk),
        .op_a     (mul_a),
        .op_b     (mul_b),
        .prod_reg (prod)
    );

    wcsm_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (num_reg),
        .divisor  (prod[DEN_W-1:0]),
        .status   (div_st),
        .quotient (quotient)
    );

    // zero divisor only comes from zero pulses per turn
    assign sat   = den_zero_reg || (quotient > NUM_W'(max_cfg_reg));
    assign speed = sat ? max_cfg_reg : quotient[SPEED_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_cfg_reg <= RST_WHEEL_CHANNEL;
            dist_cfg_reg <= RST_DISTANCE;
            ppt_cfg_reg  <= RST_PULSES;
            tick_cfg_reg <= RST_TICK_HZ;
            max_cfg_reg  <= RST_MAX_SPEED;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_WHEEL_CHANNEL: chan_cfg_reg <= cfg_wdata[CHAN_W-1:0];
                REG_DISTANCE:      dist_cfg_reg <= cfg_wdata[DIST_W-1:0];
                REG_PULSES:        ppt_cfg_reg  <= cfg_wdata[PPT_W-1:0];
                REG_TICK_HZ:       tick_cfg_reg <= cfg_wdata[TICK_W-1:0];
                REG_MAX_SPEED:     max_cfg_reg  <= cfg_wdata[SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            have_prev_reg  <= 1'b0;
            prev_count_reg <= '0;
            m_tvalid       <= 1'b0;
        end else begin
            // in S_OUT the result register is reloaded below instead
            if (m_tvalid && m_tready && (state_reg != S_OUT)) begin
                m_tvalid <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (in_xfer && (s_tuser == chan_cfg_reg)) begin
                        prev_count_reg <= now_count;
                        have_prev_reg  <= 1'b1;
                        period_reg     <= period_next;
                        if (have_prev_reg && (period_next != '0)) begin
                            state_reg <= S_NUM;
                        end
                    end
                end
                S_NUM: begin
                    state_reg <= S_K;
                end
                S_K: begin
                    num_reg   <= prod[NUM_W-1:0];
                    state_reg <= S_DEN;
                end
                S_DEN: begin
                    state_reg <= S_LOAD;
                end
                S_LOAD: begin
                    den_zero_reg <= (prod[DEN_W-1:0] == '0);
                    state_reg    <= S_DIV;
                end
                S_DIV: begin
                    if (div_st.done) begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    // hold until the previous result transfer is done
                    if (out_free) begin
                        m_tvalid  <= 1'b1;
                        m_tdata   <= {PERIOD_W'(period_reg), speed};
                        m_tuser   <= sat;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: hdl/wcsm_checker.sv
// ----------------------------------------------------------------------------
// wcsm_checker - port-level checks for the wheel speed meter
// Watches the top level's ports and is bound to it below.
// ----------------------------------------------------------------------------
`default_nettype none

module wcsm_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata,
    input wire logic        m_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // reset leaves no result pending
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a reported period is never zero
    a_period_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[47:16] != 32'd0)
        else $error("zero period reported");

    // a result comes only from S_OUT: none rises right after a capture
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result appeared right after a capture transfer");

endmodule

bind wheel_capture_speed_meter_core wcsm_checker u_wcsm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

FILE: test/wheel_capture_speed_meter_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wheel_capture_speed_meter_core_tb - self-checking bench for the speed meter
// Drives capture events with random gaps and register settings, predicts
// each speed result from its own copy of the capture state and registers,
// and checks every result transfer against the oldest pending prediction.
// ----------------------------------------------------------------------------

module wheel_capture_speed_meter_core_tb;

    import wcsm_pkg::*;

    localparam int IDLE_PCT     = 32;
    localparam int SETTLE_TICKS = 100;   // extra wait after draining, longer than one speed calculation
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [SPEED_W-1:0]  speed;
        logic                saturated;
        logic [PERIOD_W-1:0] period;
    } speed_result_t;

    logic                        aclk;
    logic                        aresetn;
    logic                        s_tvalid;
    logic                        s_tready;
    logic [COUNT_W-1:0]          s_tdata;   // capture_count
    logic [CHAN_W-1:0]           s_tuser;   // capture_channel
    logic                        m_tvalid;
    logic                        m_tready;
    logic [SPEED_W+PERIOD_W-1:0] m_tdata;   // speed_mm_s, period_ticks
    logic                        m_tuser;   // speed_saturated
    logic                        cfg_wr_en;
    logic [CFG_ADDR_W-1:0]       cfg_addr;
    logic [CFG_DATA_W-1:0]       cfg_wdata;

    // predicted register contents and capture state
    logic [CHAN_W-1:0]  wheel_chan;
    logic [DIST_W-1:0]  dist_um;
    logic [PPT_W-1:0]   pulses_turn;
    logic [TICK_W-1:0]  tick_rate;
    logic [SPEED_W-1:0] speed_limit;
    logic [COUNT_W-1:0] last_count;
    bit                 count_seen;

    speed_result_t speed_results_q[$];
    int            error_count;
    bit            idle_en;

    wheel_capture_speed_meter_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    // result side back-pressure
    always @(negedge aclk) begin
        m_tready <= !(idle_en && $urandom_range(99) < IDLE_PCT);
    end

    // speed prediction for one accepted capture
    function automatic bit predict_speed(input logic [CHAN_W-1:0] chan,
                                         input logic [COUNT_W-1:0] count,
                                         output speed_result_t res);
        logic [PERIOD_W-1:0] period;
        logic [63:0]         num;
        logic [63:0]         den;
        logic [63:0]         raw;
        res = '0;
        if (chan != wheel_chan) return 1'b0;
        if (!count_seen) begin
            last_count = count;
            count_seen = 1'b1;
            return 1'b0;
        end
        period     = count - last_count;
        last_count = count;
        if (period == '0) return 1'b0;
        num = 64'(dist_um) * 64'(tick_rate);
        den = 64'(UM_PER_MM) * 64'(pulses_turn) * 64'(period);
        res.period = period;
        if (den == 64'd0) begin
            res.speed     = speed_limit;
            res.saturated = 1'b1;
        end else begin
            raw = num / den;
            if (raw > 64'(speed_limit)) begin
                res.speed     = speed_limit;
                res.saturated = 1'b1;
            end else begin
                res.speed     = raw[SPEED_W-1:0];
                res.saturated = 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // one capture transfer; returns at a falling edge with s_tvalid still high
    task automatic send_capture(input logic [CHAN_W-1:0] chan,
                                input logic [COUNT_W-1:0] count);
        speed_result_t res;
        while (idle_en && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= count;
        s_tuser  <= chan;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (predict_speed(chan, count, res)) speed_results_q.push_back(res);
        @(negedge aclk);
    endtask

    // stop sending and let every pending result come out
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (speed_results_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_TICKS) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        case (idx)
            REG_WHEEL_CHANNEL: wheel_chan  = value[CHAN_W-1:0];
            REG_DISTANCE:      dist_um     = value[DIST_W-1:0];
            REG_PULSES:        pulses_turn = value[PPT_W-1:0];
            REG_TICK_HZ:       tick_rate   = value[TICK_W-1:0];
            REG_MAX_SPEED:     speed_limit = value[SPEED_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // sometimes set the bits above the register width, they must be dropped
    function automatic logic [CFG_DATA_W-1:0] add_upper_noise(input logic [CFG_DATA_W-1:0] v,
                                                            input int w);
        if ($urandom_range(3) != 0 || w >= CFG_DATA_W) return v;
        return v | (CFG_DATA_W'($urandom) & ~((CFG_DATA_W'(1) << w) - CFG_DATA_W'(1)));
    endfunction

    // log-spread tick difference, zero now and then
    function automatic logic [COUNT_W-1:0] pick_period();
        int unsigned k;
        if ($urandom_range(99) < 5) return '0;
        k = $urandom_range(32, 1);
        return COUNT_W'(64'($urandom) & ((64'd1 << k) - 64'd1));
    endfunction

    task automatic randomize_config();
        logic [CFG_DATA_W-1:0] v;
        v = CFG_DATA_W'($urandom_range(3));
        write_reg(REG_WHEEL_CHANNEL, add_upper_noise(v, CHAN_W));
        case ($urandom_range(7))
            0:       v = '0;
            1:       v = CFG_DATA_W'(1);
            2:       v = CFG_DATA_W'(20'hFFFFF);
            default: v = CFG_DATA_W'($urandom_range(20'hFFFFF, 1));
        endcase
        write_reg(REG_DISTANCE, add_upper_noise(v, DIST_W));
        case ($urandom_range(7))
            0:       v = '0;
            1:       v = CFG_DATA_W'(1);
            2:       v = CFG_DATA_W'(16'hFFFF);
            3, 4:    v = CFG_DATA_W'($urandom_range(64, 1));
            default: v = CFG_DATA_W'($urandom_range(16'hFFFF, 1));
        endcase
        write_reg(REG_PULSES, add_upper_noise(v, PPT_W));
        case ($urandom_range(7))
            0:       v = '0;
            1:       v = CFG_DATA_W'(1);
            2:       v = CFG_DATA_W'(200000000);
            3:       v = 28'hFFFFFFF;
            default: v = CFG_DATA_W'($urandom_range(200000000, 1));
        endcase
        write_reg(REG_TICK_HZ, v);
        case ($urandom_range(3))
            0:       v = '0;
            1:       v = CFG_DATA_W'(16'hFFFF);
            default: v = CFG_DATA_W'($urandom_range(16'hFFFF));
        endcase
        write_reg(REG_MAX_SPEED, add_upper_noise(v, SPEED_W));
    endtask

    // n wheel captures, other channels mixed in between
    task automatic send_random_captures(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 15)
                send_capture(wheel_chan + CHAN_W'($urandom_range(3, 1)), $urandom);
            send_capture(wheel_chan, last_count + pick_period());
        end
    endtask

    task automatic test_defaults_and_seeding();
        send_capture(2'd1, 32'hFFFF_FFFF);          // ignored channel
        send_capture(2'd0, 32'd0);                  // seeds only
        send_capture(2'd0, 32'd10000);              // exactly at the limit
        send_capture(2'd0, 32'd10000);              // equal counts
        send_capture(2'd0, 32'd10001);              // one tick
        send_capture(2'd0, 32'hFFFF_FFFF);
        send_capture(2'd0, 32'h0000_0005);          // counter wrap
        wait_drain();
    endtask

    task automatic test_register_extremes();
        write_reg(REG_PULSES, '0);                  // zero divisor
        send_capture(2'd0, last_count + 100);
        wait_drain();
        write_reg(REG_PULSES, CFG_DATA_W'(1));
        write_reg(REG_DISTANCE, '0);
        send_capture(2'd0, last_count + 100);
        wait_drain();
        write_reg(REG_DISTANCE, CFG_DATA_W'(20'hFFFFF));
        write_reg(REG_TICK_HZ, '0);
        send_capture(2'd0, last_count + 100);
        wait_drain();
        write_reg(REG_TICK_HZ, 28'hFFFFFFF);
        write_reg(REG_MAX_SPEED, '0);
        send_capture(2'd0, last_count + 100);
        wait_drain();
        write_reg(REG_MAX_SPEED, CFG_DATA_W'(16'hFFFF));
        send_capture(2'd0, last_count + 1);
        send_capture(2'd0, last_count + 32'hFFFF_FFFF);
        wait_drain();
        write_reg(REG_PULSES, CFG_DATA_W'(16'hFFFF));
        write_reg(REG_DISTANCE, CFG_DATA_W'(1));
        write_reg(REG_TICK_HZ, CFG_DATA_W'(1));
        send_capture(2'd0, last_count + 1);
        wait_drain();
        write_reg(REG_WHEEL_CHANNEL, 28'hFFFFFFE);  // upper bits dropped
        write_reg(REG_PULSES, CFG_DATA_W'(1));
        write_reg(REG_DISTANCE, CFG_DATA_W'(20'd100000));
        write_reg(REG_TICK_HZ, 28'd1000000);
        send_capture(2'd3, 32'h1234_5678);
        send_capture(2'd0, 32'h8765_4321);
        send_capture(2'd2, last_count + 32'd7000);
        wait_drain();
        write_reg(REG_WHEEL_CHANNEL, CFG_DATA_W'(3));
        send_capture(2'd1, 32'h5555_5555);
        send_capture(2'd3, last_count + 32'd25000);
        wait_drain();
    endtask

    task automatic test_streaming_no_idle();
        idle_en = 1'b0;
        randomize_config();
        send_random_captures(60);
        wait_drain();
        idle_en = 1'b1;
    endtask

    task automatic test_pause_until_drained();
        randomize_config();
        send_random_captures(12);
        wait_drain();
        send_random_captures(12);
        wait_drain();
    endtask

    task automatic test_random_phases();
        for (int p = 0; p < 6; p++) begin
            randomize_config();
            send_random_captures(55);
            wait_drain();
        end
    endtask

    // result checker
    always @(posedge aclk) begin : check_results
        speed_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (speed_results_q.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("unexpected result: speed %0d sat %0d period %0d",
                             m_tdata[SPEED_W-1:0], m_tuser, m_tdata[SPEED_W +: PERIOD_W]);
            end else begin
                want = speed_results_q.pop_front();
                if (m_tdata[SPEED_W-1:0] !== want.speed || m_tuser !== want.saturated ||
                        m_tdata[SPEED_W +: PERIOD_W] !== want.period) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("mismatch: expected speed %0d sat %0d period %0d, got %0d %0d %0d",
                                 want.speed, want.saturated, want.period,
                                 m_tdata[SPEED_W-1:0], m_tuser,
                                 m_tdata[SPEED_W +: PERIOD_W]);
                end
            end
        end
    end

    initial begin
        int guard;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        m_tready    = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_addr    = '0;
        cfg_wdata   = '0;
        error_count = 0;
        idle_en     = 1'b1;
        wheel_chan  = RST_WHEEL_CHANNEL;
        dist_um     = RST_DISTANCE;
        pulses_turn = RST_PULSES;
        tick_rate   = RST_TICK_HZ;
        speed_limit = RST_MAX_SPEED;
        last_count  = '0;
        count_seen  = 1'b0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_defaults_and_seeding();
        test_register_extremes();
        test_streaming_no_idle();
        test_pause_until_drained();
        test_random_phases();

        s_tvalid <= 1'b0;
        guard = 0;
        while (speed_results_q.size() != 0 && guard < 20000) begin
            @(negedge aclk);
            guard++;
        end
        repeat (SETTLE_TICKS) @(negedge aclk);
        if (speed_results_q.size() != 0) begin
            error_count++;
            $display("%0d expected results never arrived", speed_results_q.size());
        end
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
